// File: src/ets_pkg.sv
// Shared constants and types for the exhaustive tour search block
`default_nettype none
package ets_pkg;

	// fixed field widths of the ports
	localparam int CITY_W     = 3;
	localparam int DIST_IN_W  = 16;
	localparam int COUNT_W    = 4;
	localparam int COST_OUT_W = 19;

	// tour cost saturates here on the output
	localparam logic [COST_OUT_W-1:0] COST_OUT_MAX = '1;

	// default build sizes
	localparam int MAX_CITIES_DEF = 8;
	localparam int DIST_BITS_DEF  = 16;

	// city count after reset
	localparam logic [COUNT_W-1:0] CITY_COUNT_RST = 4'd8;

	// commands from the controller to the datapath
	typedef struct packed {
		logic wr;         // write the accepted matrix entry
		logic init;       // identity order, clear best flag
		logic load_walk;  // copy order into walk register, clear sum
		logic issue;      // read one edge, rotate walk register
		logic cmp;        // compare sum with best, find pivot
		logic perm;       // step to next lexicographic order
		logic load_out;   // load best tour into output shifter
		logic shift_out;  // advance output shifter
	} ets_cmd_t;

endpackage
`default_nettype wire

// File: src/ets_ram.sv
// Generic single write port, single read port RAM with registered read
`default_nettype none
module ets_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: src/ets_ctrl.sv
// Controller state machine for the exhaustive tour search
`default_nettype none
module ets_ctrl #(
	parameter int MAX_CITIES = ets_pkg::MAX_CITIES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire logic                              start_search,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic                              last_city,
	input  wire logic [$clog2(MAX_CITIES+1)-1:0]   n_cities,
	input  wire logic                              has_next,
	output      ets_pkg::ets_cmd_t                 cmd
);

	localparam int NB    = $clog2(MAX_CITIES + 1);
	localparam int CNT_W = $clog2(MAX_CITIES);

	typedef enum logic [2:0] {
		IDLE, INIT, LOADW, SUM, LAST, CMP, PERM, OUT
	} state_t;

	state_t           state_q;
	logic             in_ready_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic             cnt_last;
	logic             in_fire;

	assign cnt_last = (NB'(cnt_q) == (n_cities - NB'(1)));
	assign in_fire  = in_valid && in_ready_q;

	// state, counter and handshake registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			in_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					in_ready_q <= 1'b1;
					if (in_fire && start_search) begin
						in_ready_q <= 1'b0;
						state_q    <= INIT;
					end
				end
				INIT: begin
					state_q <= LOADW;
				end
				LOADW: begin
					cnt_q   <= '0;
					state_q <= SUM;
				end
				SUM: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_last) begin
						state_q <= LAST;
					end
				end
				LAST: begin
					state_q <= CMP;
				end
				CMP: begin
					state_q <= PERM;
				end
				PERM: begin
					if (has_next) begin
						state_q <= LOADW;
					end else begin
						cnt_q       <= '0;
						out_valid_q <= 1'b1;
						state_q     <= OUT;
					end
				end
				OUT: begin
					if (out_ready) begin
						if (cnt_last) begin
							out_valid_q <= 1'b0;
							in_ready_q  <= 1'b1;
							state_q     <= IDLE;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// datapath commands decoded from state
	always_comb begin
		cmd           = '0;
		cmd.wr        = (state_q == IDLE) && in_fire;
		cmd.init      = (state_q == INIT);
		cmd.load_walk = (state_q == LOADW);
		cmd.issue     = (state_q == SUM);
		cmd.cmp       = (state_q == CMP);
		cmd.perm      = (state_q == PERM) && has_next;
		cmd.load_out  = (state_q == PERM) && !has_next;
		cmd.shift_out = (state_q == OUT) && out_ready && !cnt_last;
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;
	assign last_city = out_valid_q && cnt_last;

endmodule
`default_nettype wire

// File: src/ets_dp.sv
// Datapath: distance store, tour orders, cost sum, best tracking, output shifter
`default_nettype none
module ets_dp #(
	parameter int MAX_CITIES = ets_pkg::MAX_CITIES_DEF,
	parameter int DIST_BITS  = ets_pkg::DIST_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ets_pkg::ets_cmd_t                 cmd,
	input  wire logic                              cfg_we,
	input  wire logic [ets_pkg::COUNT_W-1:0]       city_count,
	input  wire logic [ets_pkg::CITY_W-1:0]        row_city,
	input  wire logic [ets_pkg::CITY_W-1:0]        col_city,
	input  wire logic [ets_pkg::DIST_IN_W-1:0]     distance,
	output      logic [$clog2(MAX_CITIES+1)-1:0]   n_cities,
	output      logic                              has_next,
	output      logic [ets_pkg::CITY_W-1:0]        tour_city,
	output      logic [ets_pkg::COST_OUT_W-1:0]    tour_cost
);

	localparam int NB      = $clog2(MAX_CITIES + 1);
	localparam int CB      = $clog2(MAX_CITIES);
	localparam int DEPTH   = MAX_CITIES * MAX_CITIES;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int COST_W  = DIST_BITS + $clog2(MAX_CITIES);
	localparam int SAT_W   = (COST_W > ets_pkg::COST_OUT_W) ? COST_W : ets_pkg::COST_OUT_W;

	logic [ets_pkg::COUNT_W-1:0] city_count_q;
	logic [CB-1:0]               ord_q  [MAX_CITIES];
	logic [CB-1:0]               walk_q [MAX_CITIES];
	logic [CB-1:0]               best_ord_q [MAX_CITIES];
	logic [CB-1:0]               out_q  [MAX_CITIES];
	logic [COST_W-1:0]           sum_q;
	logic [COST_W-1:0]           best_q;
	logic                        have_q;
	logic                        issue_s1;
	logic [NB-1:0]               piv_q;
	logic [NB-1:0]               swp_q;
	logic                        has_next_q;
	logic [ets_pkg::COST_OUT_W-1:0] cost_out_q;

	logic                        wr_ok;
	logic [ADDR_W-1:0]           waddr;
	logic [ADDR_W-1:0]           raddr;
	logic [DIST_BITS-1:0]        rdata;
	logic [CB-1:0]               edge_to;
	logic [NB-1:0]               piv_c;
	logic [NB-1:0]               swp_c;
	logic                        found_c;
	logic [CB-1:0]               pval_c;
	logic [CB-1:0]               pval_q;
	logic [CB-1:0]               ord_nx [MAX_CITIES];
	logic [SAT_W-1:0]            best_ext;

	// city count register and clamp into 1..MAX_CITIES
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= ets_pkg::CITY_COUNT_RST;
		end else if (cfg_we) begin
			city_count_q <= city_count;
		end
	end

	always_comb begin
		if (city_count_q == '0) begin
			n_cities = NB'(1);
		end else if (int'(city_count_q) > MAX_CITIES) begin
			n_cities = NB'(MAX_CITIES);
		end else begin
			n_cities = NB'(city_count_q);
		end
	end

	// matrix write address, entries outside the store are dropped
	assign wr_ok = (int'(row_city) < MAX_CITIES) && (int'(col_city) < MAX_CITIES);
	assign waddr = ADDR_W'(int'(row_city) * MAX_CITIES + int'(col_city));

	// edge read: walk head to its successor, wrapping to itself for one city
	assign edge_to = (n_cities > NB'(1)) ? walk_q[1] : walk_q[0];
	assign raddr   = ADDR_W'(int'(walk_q[0]) * MAX_CITIES + int'(edge_to));

	ets_ram #(
		.WIDTH (DIST_BITS),
		.DEPTH (DEPTH)
	) u_dist_ram (
		.clk   (clk),
		.we    (cmd.wr && wr_ok),
		.waddr (waddr),
		.wdata (DIST_BITS'(distance)),
		.re    (cmd.issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	// pivot search: rightmost ascent at or after position one
	always_comb begin
		found_c = 1'b0;
		piv_c   = '0;
		swp_c   = '0;
		pval_c  = '0;
		for (int i = 2; i < MAX_CITIES; i++) begin
			if ((i < int'(n_cities)) && (ord_q[i-1] < ord_q[i])) begin
				found_c = 1'b1;
				piv_c   = NB'(i);
			end
		end
		for (int k = 1; k < MAX_CITIES; k++) begin
			if (k == int'(piv_c) - 1) begin
				pval_c = ord_q[k];
			end
		end
		for (int k = 1; k < MAX_CITIES; k++) begin
			if ((k < int'(n_cities)) && (k >= int'(piv_c)) && (ord_q[k] > pval_c)) begin
				swp_c = NB'(k);
			end
		end
	end

	// next order: swap pivot with the rightmost larger tail element, reverse the tail
	always_comb begin
		for (int k = 0; k < MAX_CITIES; k++) begin
			ord_nx[k] = ord_q[k];
			if (k == int'(piv_q) - 1) begin
				for (int s = 0; s < MAX_CITIES; s++) begin
					if (s == int'(swp_q)) begin
						ord_nx[k] = ord_q[s];
					end
				end
			end else if ((k >= int'(piv_q)) && (k < int'(n_cities))) begin
				for (int s = 0; s < MAX_CITIES; s++) begin
					if (s == int'(piv_q) + int'(n_cities) - 1 - k) begin
						ord_nx[k] = (s == int'(swp_q)) ? pval_q : ord_q[s];
					end
				end
			end
		end
	end

	// control flags of the search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			issue_s1   <= 1'b0;
			has_next_q <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
			if (cmd.init) begin
				have_q <= 1'b0;
			end else if (cmd.cmp) begin
				have_q <= 1'b1;
			end
			if (cmd.cmp) begin
				has_next_q <= found_c;
			end
		end
	end

	// orders, cost sum, best tour and output shifter
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			for (int k = 0; k < MAX_CITIES; k++) begin
				ord_q[k] <= CB'(k);
			end
		end else if (cmd.perm) begin
			ord_q <= ord_nx;
		end

		if (cmd.load_walk) begin
			walk_q <= ord_q;
		end else if (cmd.issue) begin
			for (int k = 0; k < MAX_CITIES; k++) begin
				if (k == int'(n_cities) - 1) begin
					walk_q[k] <= walk_q[0];
				end else if (k < MAX_CITIES - 1) begin
					walk_q[k] <= walk_q[k+1];
				end
			end
		end

		if (cmd.load_walk) begin
			sum_q <= '0;
		end else if (issue_s1) begin
			sum_q <= sum_q + COST_W'(rdata);
		end

		if (cmd.cmp) begin
			piv_q  <= piv_c;
			swp_q  <= swp_c;
			pval_q <= pval_c;
			if (!have_q || (sum_q < best_q)) begin
				best_q     <= sum_q;
				best_ord_q <= ord_q;
			end
		end

		if (cmd.load_out) begin
			out_q <= best_ord_q;
			if (best_ext > SAT_W'(ets_pkg::COST_OUT_MAX)) begin
				cost_out_q <= ets_pkg::COST_OUT_MAX;
			end else begin
				cost_out_q <= best_ext[ets_pkg::COST_OUT_W-1:0];
			end
		end else if (cmd.shift_out) begin
			for (int k = 0; k < MAX_CITIES - 1; k++) begin
				out_q[k] <= out_q[k+1];
			end
		end
	end

	assign best_ext  = SAT_W'(best_q);
	assign has_next  = has_next_q;
	assign tour_city = ets_pkg::CITY_W'(out_q[0]);
	assign tour_cost = cost_out_q;

endmodule
`default_nettype wire

// File: src/exhaustive_tour_search.sv
// Top level of the exhaustive closed-tour search block
//
// channel   direction  handshake              word
// in        input      in_valid / in_ready    row_city, col_city, distance, start_search
// out       output     out_valid / out_ready  tour_city, tour_cost, last_city
// cfg       input      cfg_valid / cfg_ready  city_count
//
// a matrix entry word without start_search is written and gives no output
// a start word writes its entry, then runs (n-1)! tours, each with a walk load,
// one distance store read per edge, then compare and permutation step
// the best tour leaves as n words, one city each, held while out_ready is low
// reset clears control state and resets the city count; distance entries hold garbage until written
`default_nettype none
module exhaustive_tour_search #(
	parameter int MAX_CITIES = ets_pkg::MAX_CITIES_DEF,
	parameter int DIST_BITS  = ets_pkg::DIST_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire logic [ets_pkg::CITY_W-1:0]        row_city,
	input  wire logic [ets_pkg::CITY_W-1:0]        col_city,
	input  wire logic [ets_pkg::DIST_IN_W-1:0]     distance,
	input  wire logic                              start_search,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic [ets_pkg::CITY_W-1:0]        tour_city,
	output      logic [ets_pkg::COST_OUT_W-1:0]    tour_cost,
	output      logic                              last_city,
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [ets_pkg::COUNT_W-1:0]       city_count
);

	ets_pkg::ets_cmd_t                 cmd;
	logic [$clog2(MAX_CITIES+1)-1:0]   n_cities;
	logic                              has_next;

	// config register is always writable
	assign cfg_ready = 1'b1;

	ets_ctrl #(
		.MAX_CITIES (MAX_CITIES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_search (start_search),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.last_city    (last_city),
		.n_cities     (n_cities),
		.has_next     (has_next),
		.cmd          (cmd)
	);

	ets_dp #(
		.MAX_CITIES (MAX_CITIES),
		.DIST_BITS  (DIST_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_valid && cfg_ready),
		.city_count (city_count),
		.row_city   (row_city),
		.col_city   (col_city),
		.distance   (distance),
		.n_cities   (n_cities),
		.has_next   (has_next),
		.tour_city  (tour_city),
		.tour_cost  (tour_cost)
	);

endmodule
`default_nettype wire
